// ===== rtl/spc_pkg.sv =====
// Shared types, character codes and the normal-text transition for the bind marker scanner.
package spc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int MARKER_BITS    = 16;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ANSI_QUOTES   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_BACKSLASH  = 1'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    typedef enum logic [3:0] {
        M_NORMAL   = 4'd0,
        M_DASH     = 4'd1,
        M_SLASH    = 4'd2,
        M_LINE     = 4'd3,
        M_BLOCK    = 4'd4,
        M_STAR     = 4'd5,
        M_SQ       = 4'd6,
        M_SQ_ESC   = 4'd7,
        M_SQ_QUOTE = 4'd8,
        M_DQ       = 4'd9,
        M_DQ_ESC   = 4'd10,
        M_DQ_QUOTE = 4'd11
    } t_scan_mode;

    typedef struct packed {
        logic       step;
        logic [7:0] stmt_byte;
        logic       last;
        logic       ansi_quotes;
        logic       no_bs_esc;
    } t_scan_req;

    function automatic t_scan_mode normal_next(input logic [7:0] b, input logic ansi);
        t_scan_mode m;
        m = M_NORMAL;
        if (b == CH_DASH) begin
            m = M_DASH;
        end else if (b == CH_SLASH) begin
            m = M_SLASH;
        end else if (b == CH_SQUOTE) begin
            m = M_SQ;
        end else if (b == CH_DQUOTE && !ansi) begin
            m = M_DQ;
        end
        return m;
    endfunction

endpackage

// ===== rtl/spc_scanner.sv =====
// Scan mode state machine and saturating marker counter.
module spc_scanner #(
    parameter int COUNT_BITS = spc_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spc_pkg::t_scan_req    i_req,
    output logic                  o_end,
    output logic [COUNT_BITS-1:0] o_count
);

    spc_pkg::t_scan_mode   r_mode;
    spc_pkg::t_scan_mode   n_mode;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  mark;
    logic                  esc;
    logic [7:0]            b;

    assign b   = i_req.stmt_byte;
    assign esc = !i_req.no_bs_esc;

    always_comb begin
        n_mode = r_mode;
        mark   = 1'b0;
        case (r_mode)
            spc_pkg::M_DASH: begin
                if (b == spc_pkg::CH_DASH) begin
                    n_mode = spc_pkg::M_LINE;
                end else begin
                    n_mode = spc_pkg::normal_next(b, i_req.ansi_quotes);
                    mark   = (b == spc_pkg::CH_QMARK);
                end
            end
            spc_pkg::M_SLASH: begin
                if (b == spc_pkg::CH_STAR) begin
                    n_mode = spc_pkg::M_BLOCK;
                end else if (b == spc_pkg::CH_SLASH) begin
                    n_mode = spc_pkg::M_LINE;
                end else begin
                    n_mode = spc_pkg::normal_next(b, i_req.ansi_quotes);
                    mark   = (b == spc_pkg::CH_QMARK);
                end
            end
            spc_pkg::M_LINE: begin
                if (b == spc_pkg::CH_NL) begin
                    n_mode = spc_pkg::M_NORMAL;
                end
            end
            spc_pkg::M_BLOCK: begin
                if (b == spc_pkg::CH_STAR) begin
                    n_mode = spc_pkg::M_STAR;
                end
            end
            spc_pkg::M_STAR: begin
                if (b == spc_pkg::CH_SLASH) begin
                    n_mode = spc_pkg::M_NORMAL;
                end else if (b != spc_pkg::CH_STAR) begin
                    n_mode = spc_pkg::M_BLOCK;
                end
            end
            spc_pkg::M_SQ: begin
                if (b == spc_pkg::CH_SQUOTE) begin
                    n_mode = spc_pkg::M_SQ_QUOTE;
                end else if (b == spc_pkg::CH_BSLASH && esc) begin
                    n_mode = spc_pkg::M_SQ_ESC;
                end
            end
            spc_pkg::M_SQ_ESC: begin
                n_mode = spc_pkg::M_SQ;
            end
            spc_pkg::M_SQ_QUOTE: begin
                if (b == spc_pkg::CH_SQUOTE) begin
                    n_mode = spc_pkg::M_SQ;
                end else begin
                    n_mode = spc_pkg::normal_next(b, i_req.ansi_quotes);
                    mark   = (b == spc_pkg::CH_QMARK);
                end
            end
            spc_pkg::M_DQ: begin
                if (b == spc_pkg::CH_DQUOTE) begin
                    n_mode = spc_pkg::M_DQ_QUOTE;
                end else if (b == spc_pkg::CH_BSLASH && esc) begin
                    n_mode = spc_pkg::M_DQ_ESC;
                end
            end
            spc_pkg::M_DQ_ESC: begin
                n_mode = spc_pkg::M_DQ;
            end
            spc_pkg::M_DQ_QUOTE: begin
                if (b == spc_pkg::CH_DQUOTE) begin
                    n_mode = spc_pkg::M_DQ;
                end else begin
                    n_mode = spc_pkg::normal_next(b, i_req.ansi_quotes);
                    mark   = (b == spc_pkg::CH_QMARK);
                end
            end
            default: begin
                n_mode = spc_pkg::normal_next(b, i_req.ansi_quotes);
                mark   = (b == spc_pkg::CH_QMARK);
            end
        endcase
        // zero byte is not scanned
        if (b == spc_pkg::CH_NUL) begin
            mark = 1'b0;
        end
        n_count = (mark && (r_count != {COUNT_BITS{1'b1}})) ?
                  r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1} : r_count;
    end

    assign o_end   = (b == spc_pkg::CH_NUL) || i_req.last;
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= spc_pkg::M_NORMAL;
            r_count <= '0;
        end else if (i_req.step) begin
            if (o_end) begin
                r_mode  <= spc_pkg::M_NORMAL;
                r_count <= '0;
            end else begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.step && o_end |=> r_mode == spc_pkg::M_NORMAL && r_count == '0)
        else $error("scanner did not restart after statement end");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.step && !o_end |=> r_count >= $past(r_count))
        else $error("marker count decreased within a statement");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.step |=> $stable(r_count) && $stable(r_mode))
        else $error("scanner state moved without a beat");

endmodule

// ===== rtl/sql_placeholder_counter.sv =====
// Top level: input beat register, scanner and saturating result register.
// Accepts one statement byte per cycle while the input is not stalled; the byte that
// ends the statement passes the input register, then the result register, and the
// scanner state updates in one pass between them. Input stall rises only when
// a statement-ending byte sits in the input register while the result register
// is full and stalled. Configuration bits apply to bytes scanned after the write.
module sql_placeholder_counter #(
    parameter int COUNT_BITS = spc_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_stmt_byte,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [spc_pkg::MARKER_BITS-1:0]     o_marker_count,
    input  logic                                i_cfg_we,
    input  logic [spc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [spc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic                              r_ansi_quotes;
    logic                              r_no_backslash;
    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              r_in_last;
    logic                              r_out_valid;
    logic [spc_pkg::MARKER_BITS-1:0]   r_out_count;
    logic [spc_pkg::MARKER_BITS-1:0]   sat_count;
    logic [COUNT_BITS-1:0]             scan_count;
    logic                              scan_end;
    logic                              out_free;
    logic                              proc;
    logic                              in_take;
    spc_pkg::t_scan_req                req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ansi_quotes  <= 1'b0;
            r_no_backslash <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spc_pkg::CFG_ANSI_QUOTES:  r_ansi_quotes  <= i_cfg_data[0];
                spc_pkg::CFG_NO_BACKSLASH: r_no_backslash <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!scan_end || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        req.step        = proc;
        req.stmt_byte   = r_in_byte;
        req.last        = r_in_last;
        req.ansi_quotes = r_ansi_quotes;
        req.no_bs_esc   = r_no_backslash;
    end

    spc_scanner #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_end   (scan_end),
        .o_count (scan_count)
    );

    generate
        if (COUNT_BITS > spc_pkg::MARKER_BITS) begin : g_sat_wide
            assign sat_count = (|scan_count[COUNT_BITS-1:spc_pkg::MARKER_BITS]) ?
                               {spc_pkg::MARKER_BITS{1'b1}} :
                               scan_count[spc_pkg::MARKER_BITS-1:0];
        end else begin : g_sat_narrow
            assign sat_count = spc_pkg::MARKER_BITS'(scan_count);
        end
    endgenerate

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_stmt_byte;
            r_in_last <= i_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && scan_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && scan_end) begin
            r_out_count <= sat_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_marker_count = r_out_count;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && scan_end)
        else $error("input stalled without a blocked result");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && scan_end |=> r_out_valid)
        else $error("statement end did not produce a result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc |=> r_in_valid && r_in_byte == $past(r_in_byte))
        else $error("blocked byte lost from input register");

endmodule

// ===== tb/sv/tb_sql_placeholder_counter.sv =====
// Self-checking testbench for the SQL bind marker scanner: queued stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module tb_sql_placeholder_counter;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_stmt_beat;

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_in_valid     = 1'b0;
    logic                              o_in_stall;
    logic [7:0]                        i_stmt_byte    = 8'h00;
    logic                              i_last         = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall    = 1'b0;
    logic [spc_pkg::MARKER_BITS-1:0]   o_marker_count;
    logic                              i_cfg_we       = 1'b0;
    logic [spc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx      = spc_pkg::CFG_ANSI_QUOTES;
    logic [spc_pkg::CFG_DATA_BITS-1:0] i_cfg_data     = '0;

    t_stmt_beat                      byte_pending[$];
    logic [spc_pkg::MARKER_BITS-1:0] marker_exp[$];

    spc_pkg::t_scan_mode             scan_st = spc_pkg::M_NORMAL;
    logic [spc_pkg::MARKER_BITS-1:0] run_cnt = '0;
    logic                            cfg_ansi = 1'b0;
    logic                            cfg_nobs = 1'b0;

    int                              errors = 0;
    int                              rand_beats = 0;
    bit                              in_burst = 1'b0;
    bit                              out_burst = 1'b0;
    int                              in_gap = 0;
    int                              out_hold = 0;
    t_stmt_beat                      next_beat;
    logic [spc_pkg::MARKER_BITS-1:0] pred_cnt;
    logic [spc_pkg::MARKER_BITS-1:0] want_cnt;

    string plain_set = "SELECTa1 =,()*\n;";

    sql_placeholder_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stmt_byte    (i_stmt_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_marker_count (o_marker_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void scan_text(input logic [7:0] b);
        scan_st = spc_pkg::M_NORMAL;
        if (b == spc_pkg::CH_QMARK) begin
            if (run_cnt != {spc_pkg::MARKER_BITS{1'b1}}) run_cnt = run_cnt + 1'b1;
        end else if (b == spc_pkg::CH_DASH) begin
            scan_st = spc_pkg::M_DASH;
        end else if (b == spc_pkg::CH_SLASH) begin
            scan_st = spc_pkg::M_SLASH;
        end else if (b == spc_pkg::CH_SQUOTE) begin
            scan_st = spc_pkg::M_SQ;
        end else if (b == spc_pkg::CH_DQUOTE && !cfg_ansi) begin
            scan_st = spc_pkg::M_DQ;
        end
    endfunction

    function automatic bit predict_marker_beat(input logic [7:0] b, input logic fin,
                                               output logic [spc_pkg::MARKER_BITS-1:0] cnt);
        bit esc;
        esc = !cfg_nobs;
        cnt = run_cnt;
        if (b == spc_pkg::CH_NUL) begin
            scan_st = spc_pkg::M_NORMAL;
            run_cnt = '0;
            return 1'b1;
        end
        case (scan_st)
            spc_pkg::M_DASH: begin
                if (b == spc_pkg::CH_DASH) scan_st = spc_pkg::M_LINE; else scan_text(b);
            end
            spc_pkg::M_SLASH: begin
                if (b == spc_pkg::CH_STAR) scan_st = spc_pkg::M_BLOCK;
                else if (b == spc_pkg::CH_SLASH) scan_st = spc_pkg::M_LINE;
                else scan_text(b);
            end
            spc_pkg::M_LINE: begin
                if (b == spc_pkg::CH_NL) scan_st = spc_pkg::M_NORMAL;
            end
            spc_pkg::M_BLOCK: begin
                if (b == spc_pkg::CH_STAR) scan_st = spc_pkg::M_STAR;
            end
            spc_pkg::M_STAR: begin
                if (b == spc_pkg::CH_SLASH) scan_st = spc_pkg::M_NORMAL;
                else if (b != spc_pkg::CH_STAR) scan_st = spc_pkg::M_BLOCK;
            end
            spc_pkg::M_SQ: begin
                if (b == spc_pkg::CH_SQUOTE) scan_st = spc_pkg::M_SQ_QUOTE;
                else if (b == spc_pkg::CH_BSLASH && esc) scan_st = spc_pkg::M_SQ_ESC;
            end
            spc_pkg::M_SQ_ESC: scan_st = spc_pkg::M_SQ;
            spc_pkg::M_SQ_QUOTE: begin
                if (b == spc_pkg::CH_SQUOTE) scan_st = spc_pkg::M_SQ; else scan_text(b);
            end
            spc_pkg::M_DQ: begin
                if (b == spc_pkg::CH_DQUOTE) scan_st = spc_pkg::M_DQ_QUOTE;
                else if (b == spc_pkg::CH_BSLASH && esc) scan_st = spc_pkg::M_DQ_ESC;
            end
            spc_pkg::M_DQ_ESC: scan_st = spc_pkg::M_DQ;
            spc_pkg::M_DQ_QUOTE: begin
                if (b == spc_pkg::CH_DQUOTE) scan_st = spc_pkg::M_DQ; else scan_text(b);
            end
            default: scan_text(b);
        endcase
        cnt = run_cnt;
        if (fin) begin
            scan_st = spc_pkg::M_NORMAL;
            run_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // input side: predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_marker_beat(i_stmt_byte, i_last, pred_cnt))
                marker_exp.push_back(pred_cnt);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_pending.size() != 0) begin
                next_beat = byte_pending.pop_front();
                i_stmt_byte <= next_beat.data;
                i_last      <= next_beat.fin;
                i_in_valid  <= 1'b1;
                if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (marker_exp.size() == 0) begin
                    $display("%0t: marker count expected none, actual %0d", $time,
                             o_marker_count);
                    errors++;
                end else begin
                    want_cnt = marker_exp.pop_front();
                    if (o_marker_count !== want_cnt) begin
                        $display("%0t: marker count expected %0d, actual %0d", $time,
                                 want_cnt, o_marker_count);
                        errors++;
                    end
                end
                if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, 10);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] pick_plain();
        return plain_set[$urandom_range(0, plain_set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_inner();
        case ($urandom_range(0, 8))
            0: return spc_pkg::CH_QMARK;
            1: return pick_plain();
            2: return spc_pkg::CH_BSLASH;
            3: return spc_pkg::CH_SQUOTE;
            4: return spc_pkg::CH_DQUOTE;
            5: return spc_pkg::CH_STAR;
            6: return spc_pkg::CH_SLASH;
            7: return spc_pkg::CH_DASH;
            default: return spc_pkg::CH_NL;
        endcase
    endfunction

    task automatic drain(input int settle);
        while (byte_pending.size() != 0 || i_in_valid || marker_exp.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [spc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [spc_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == spc_pkg::CFG_ANSI_QUOTES) cfg_ansi = val[0];
        else cfg_nobs = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input logic ansi, input logic nobs);
        drain(4);
        write_cfg(spc_pkg::CFG_ANSI_QUOTES, ansi);
        write_cfg(spc_pkg::CFG_NO_BACKSLASH, nobs);
    endtask

    // ends: 0 = last on final byte, 1 = zero byte, 2 = zero byte with last
    task automatic send_stmt(input logic [7:0] body[$], input int ends);
        foreach (body[i])
            byte_pending.push_back('{body[i], (ends == 0 && i == body.size() - 1)});
        if (ends != 0) byte_pending.push_back('{spc_pkg::CH_NUL, ends == 2});
        rand_beats += body.size() + (ends != 0);
    endtask

    task automatic send_text(input string s, input int ends);
        logic [7:0] body[$];
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
        send_stmt(body, ends);
    endtask

    task automatic gen_stmt();
        logic [7:0] body[$];
        logic [7:0] q;
        int         sel;
        int         k;
        repeat ($urandom_range(1, 8)) begin
            sel = $urandom_range(0, 11);
            case (sel)
                0, 1: body.push_back(spc_pkg::CH_QMARK);
                2: repeat ($urandom_range(1, 3)) body.push_back(pick_plain());
                3: begin
                    q = $urandom_range(0, 1) ? spc_pkg::CH_DASH : spc_pkg::CH_SLASH;
                    body.push_back(q);
                    body.push_back(q);
                    repeat ($urandom_range(0, 4)) body.push_back(pick_inner());
                    if ($urandom_range(0, 5) != 0) body.push_back(spc_pkg::CH_NL);
                end
                4: begin
                    body.push_back(spc_pkg::CH_SLASH);
                    body.push_back(spc_pkg::CH_STAR);
                    repeat ($urandom_range(0, 5)) body.push_back(pick_inner());
                    if ($urandom_range(0, 5) != 0) begin
                        body.push_back(spc_pkg::CH_STAR);
                        body.push_back(spc_pkg::CH_SLASH);
                    end
                end
                5, 6: begin
                    q = (sel == 5) ? spc_pkg::CH_SQUOTE : spc_pkg::CH_DQUOTE;
                    body.push_back(q);
                    repeat ($urandom_range(0, 5)) begin
                        k = $urandom_range(0, 3);
                        if (k == 0) begin
                            body.push_back(q);
                            body.push_back(q);
                        end else if (k == 1) begin
                            body.push_back(spc_pkg::CH_BSLASH);
                            body.push_back(pick_inner());
                        end else begin
                            body.push_back(pick_inner());
                        end
                    end
                    if ($urandom_range(0, 5) != 0) body.push_back(q);
                end
                7: begin
                    body.push_back($urandom_range(0, 1) ? spc_pkg::CH_DASH : spc_pkg::CH_SLASH);
                    body.push_back(pick_inner());
                end
                8: body.push_back(8'($urandom_range(0, 255)));
                9: body.push_back($urandom_range(0, 1) ? spc_pkg::CH_BSLASH : spc_pkg::CH_STAR);
                10: begin
                    q = $urandom_range(0, 1) ? spc_pkg::CH_SQUOTE : spc_pkg::CH_DQUOTE;
                    body.push_back(q);
                    body.push_back(q);
                end
                default: body.push_back(pick_inner());
            endcase
        end
        send_stmt(body, $urandom_range(0, 2));
    endtask

    initial begin
        logic [7:0] body[$];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_cfg(1'b0, 1'b0);
        send_text("?", 0);
        send_text("-?", 1);
        send_text("--?\n?", 0);
        send_text("/**?*/?", 0);
        send_text("'?''\\'?'?", 0);
        send_text("\"?\"?", 2);
        send_text("'\\", 0);
        send_text("", 2);
        body = '{8'hFF, 8'h80, spc_pkg::CH_QMARK};
        send_stmt(body, 0);
        rand_beats = 0;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_cfg(1'b1, 1'b1);
                1: set_cfg(1'b0, 1'b1);
                2: set_cfg(1'b1, 1'b0);
                3: set_cfg(1'b0, 1'b0);
                default: set_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            while (rand_beats < (ph + 1) * 142) gen_stmt();
        end

        drain(10);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
